### rtl/core/bgd_pkg.sv
package bgd_pkg;

   // number of button lanes, and how many of them the result reports
   localparam int NUM_BUTTONS   = 3;
   localparam int NUM_REPORTED  = (NUM_BUTTONS < 3) ? NUM_BUTTONS : 3;
   localparam int MASK_WIDTH    = 3;
   localparam int TIME_WIDTH    = 32;
   localparam int THRESH_WIDTH  = 16;
   localparam int CODE_WIDTH    = 4;

   // register map
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TAP_TIME  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HOLD_TIME = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WAIT_TIME = 2'd2;

   localparam logic [THRESH_WIDTH-1:0] TAP_TIME_RESET  = 16'd150;
   localparam logic [THRESH_WIDTH-1:0] HOLD_TIME_RESET = 16'd1000;
   localparam logic [THRESH_WIDTH-1:0] WAIT_TIME_RESET = 16'd300;

   typedef enum logic [CODE_WIDTH-1:0] {
      GESTURE_NONE      = 4'd0,
      GESTURE_TAP       = 4'd1,
      GESTURE_TAP2      = 4'd2,
      GESTURE_TAP3      = 4'd3,
      GESTURE_PRESS     = 4'd4,
      GESTURE_HOLD      = 4'd5,
      GESTURE_HOLD2     = 4'd6,
      GESTURE_TAP1_W    = 4'd7,
      GESTURE_TAP2_W    = 4'd8,
      GESTURE_TAP3_W    = 4'd9,
      GESTURE_RELEASE   = 4'd10,
      GESTURE_RELEASE_S = 4'd11,
      GESTURE_RELEASE_L = 4'd12,
      GESTURE_TAP2_R    = 4'd13,
      GESTURE_TAP3_R    = 4'd14
   } gesture_type;

   typedef struct packed {
      logic [THRESH_WIDTH-1:0] tap_time;
      logic [THRESH_WIDTH-1:0] hold_time;
      logic [THRESH_WIDTH-1:0] wait_time;
   } timing_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0] pressed_mask;
      logic [TIME_WIDTH-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] gesture_a;
      logic [CODE_WIDTH-1:0] gesture_b;
      logic [CODE_WIDTH-1:0] gesture_c;
   } rsp_type;

   // per-lane step control from the top level
   typedef struct packed {
      logic                  step;
      logic                  pressed;
      logic [TIME_WIDTH-1:0] now_ms;
   } lane_ctrl_type;

endpackage

### rtl/core/bgd_lane.sv
module bgd_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  bgd_pkg::lane_ctrl_type ctrl,
   input  bgd_pkg::timing_type   timing,
   output bgd_pkg::gesture_type  state
);

   bgd_pkg::gesture_type                  state_ff, state_in;
   logic [bgd_pkg::TIME_WIDTH-1:0]        mark_ff, mark_in;
   logic [bgd_pkg::TIME_WIDTH-1:0]        elapsed;
   logic                                  past_tap, past_hold, past_wait;

   // wrapping elapsed time and strict threshold compares
   assign elapsed   = ctrl.now_ms - mark_ff;
   assign past_tap  = elapsed > {{(bgd_pkg::TIME_WIDTH-bgd_pkg::THRESH_WIDTH){1'b0}},
                                 timing.tap_time};
   assign past_hold = elapsed > {{(bgd_pkg::TIME_WIDTH-bgd_pkg::THRESH_WIDTH){1'b0}},
                                 timing.hold_time};
   assign past_wait = elapsed > {{(bgd_pkg::TIME_WIDTH-bgd_pkg::THRESH_WIDTH){1'b0}},
                                 timing.wait_time};

   // gesture machine, pressed and released branches
   always_comb begin
      state_in = state_ff;
      mark_in  = mark_ff;
      if (ctrl.pressed) begin
         case (state_ff)
            bgd_pkg::GESTURE_NONE: begin
               state_in = bgd_pkg::GESTURE_TAP;
               mark_in  = ctrl.now_ms;
            end
            bgd_pkg::GESTURE_TAP: begin
               if (past_tap) state_in = bgd_pkg::GESTURE_PRESS;
            end
            bgd_pkg::GESTURE_TAP2: begin
               if (past_hold) state_in = bgd_pkg::GESTURE_HOLD2;
            end
            bgd_pkg::GESTURE_TAP3: begin
               if (past_hold) state_in = bgd_pkg::GESTURE_RELEASE;
            end
            bgd_pkg::GESTURE_PRESS: begin
               if (past_hold) state_in = bgd_pkg::GESTURE_HOLD;
            end
            bgd_pkg::GESTURE_TAP1_W: begin
               state_in = bgd_pkg::GESTURE_TAP2;
               mark_in  = ctrl.now_ms;
            end
            bgd_pkg::GESTURE_TAP2_W: begin
               state_in = bgd_pkg::GESTURE_TAP3;
               mark_in  = ctrl.now_ms;
            end
            bgd_pkg::GESTURE_TAP3_W: begin
               if (past_hold) state_in = bgd_pkg::GESTURE_RELEASE;
            end
            bgd_pkg::GESTURE_RELEASE,
            bgd_pkg::GESTURE_RELEASE_S,
            bgd_pkg::GESTURE_RELEASE_L: begin
               state_in = bgd_pkg::GESTURE_TAP;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end else begin
         case (state_ff)
            bgd_pkg::GESTURE_TAP: begin
               state_in = bgd_pkg::GESTURE_TAP1_W;
               mark_in  = ctrl.now_ms;
            end
            bgd_pkg::GESTURE_TAP2: begin
               state_in = bgd_pkg::GESTURE_TAP2_W;
               mark_in  = ctrl.now_ms;
            end
            bgd_pkg::GESTURE_TAP3: begin
               state_in = bgd_pkg::GESTURE_RELEASE;
               mark_in  = ctrl.now_ms;
            end
            bgd_pkg::GESTURE_PRESS: begin
               state_in = bgd_pkg::GESTURE_RELEASE_S;
            end
            bgd_pkg::GESTURE_TAP1_W: begin
               if (past_wait) state_in = bgd_pkg::GESTURE_RELEASE_S;
            end
            bgd_pkg::GESTURE_HOLD,
            bgd_pkg::GESTURE_HOLD2: begin
               state_in = bgd_pkg::GESTURE_RELEASE_L;
            end
            bgd_pkg::GESTURE_TAP2_W: begin
               if (past_wait) state_in = bgd_pkg::GESTURE_TAP2_R;
            end
            bgd_pkg::GESTURE_TAP3_W: begin
               if (past_wait) state_in = bgd_pkg::GESTURE_TAP3_R;
            end
            bgd_pkg::GESTURE_RELEASE,
            bgd_pkg::GESTURE_RELEASE_S,
            bgd_pkg::GESTURE_RELEASE_L,
            bgd_pkg::GESTURE_TAP2_R,
            bgd_pkg::GESTURE_TAP3_R: begin
               state_in = bgd_pkg::GESTURE_NONE;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // state and time mark, updated once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgd_pkg::GESTURE_NONE;
         mark_ff  <= '0;
      end else if (ctrl.step) begin
         state_ff <= state_in;
         mark_ff  <= mark_in;
      end
   end

   // next state as seen by the result stage
   assign state = state_in;

   // checks
   a_none_to_tap: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && state_ff == bgd_pkg::GESTURE_NONE)
      |=> (state_ff == bgd_pkg::GESTURE_TAP || state_ff == bgd_pkg::GESTURE_NONE))
      else $error("lane left idle to something other than tap");

   a_hold_stays: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && ctrl.pressed && state_ff == bgd_pkg::GESTURE_HOLD)
      |=> state_ff == bgd_pkg::GESTURE_HOLD)
      else $error("held button left hold");

   a_no_step_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.step |=> ($stable(state_ff) && $stable(mark_ff)))
      else $error("lane state moved without an item");

endmodule

### rtl/core/bgd_merge.sv
module bgd_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bgd_pkg::gesture_type lane_state [bgd_pkg::NUM_BUTTONS],
   output logic                 accept,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bgd_pkg::rsp_type     rsp_data
);

   logic [bgd_pkg::CODE_WIDTH-1:0] codes [3];
   bgd_pkg::rsp_type               merged;
   bgd_pkg::rsp_type               out_ff, out_in, skid_ff, skid_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           skid_valid_ff, skid_valid_in;
   logic                           take;

   // gather lane codes, absent buttons report zero
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         codes[k] = '0;
      end
      for (int i = 0; i < bgd_pkg::NUM_REPORTED; i++) begin
         codes[i] = lane_state[i];
      end
      merged.gesture_a = codes[0];
      merged.gesture_b = codes[1];
      merged.gesture_c = codes[2];
   end

   // handshake: input stalls only while the skid stage is occupied
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   // output register with skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_in       = merged;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = accept;
         out_in       = merged;
      end else if (accept) begin
         skid_in       = merged;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && accept) |=> skid_valid_ff)
      else $error("item accepted under stall was not kept");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid stage did not drain into output register");

endmodule

### rtl/core/button_gesture_detector_unit.sv
// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall     bgd_pkg::req_type (pressed_mask, now_ms)
// rsp_      out        rsp_valid / rsp_stall     bgd_pkg::rsp_type (gesture_a/b/c)
// csr_      in         apb-style, pready high    tap_time, hold_time, wait_time at 0, 4, 8
//
// one item per cycle sustained while rsp_stall is low; each result is built from the
// lane next states when its item is accepted and held in the output register or skid stage.
// reset clears lane states, time marks and output valids, and loads the
// timing registers with their defaults.
// a stalled result is held; one further item lands in the skid stage, after
// which req_stall rises until the output drains.
module button_gesture_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bgd_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bgd_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bgd_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [bgd_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [bgd_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   bgd_pkg::timing_type              timing_ff, timing_in;
   logic [bgd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic                             csr_write;
   logic                             accept;
   bgd_pkg::gesture_type             lane_state [bgd_pkg::NUM_BUTTONS];

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[bgd_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      timing_in = timing_ff;
      if (csr_write) begin
         case (csr_index)
            bgd_pkg::REG_TAP_TIME:
               timing_in.tap_time  = csr_pwdata[bgd_pkg::THRESH_WIDTH-1:0];
            bgd_pkg::REG_HOLD_TIME:
               timing_in.hold_time = csr_pwdata[bgd_pkg::THRESH_WIDTH-1:0];
            bgd_pkg::REG_WAIT_TIME:
               timing_in.wait_time = csr_pwdata[bgd_pkg::THRESH_WIDTH-1:0];
            default: begin
               timing_in = timing_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.tap_time  <= bgd_pkg::TAP_TIME_RESET;
         timing_ff.hold_time <= bgd_pkg::HOLD_TIME_RESET;
         timing_ff.wait_time <= bgd_pkg::WAIT_TIME_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         bgd_pkg::REG_TAP_TIME:
            csr_prdata = {{(bgd_pkg::CSR_DATA_WIDTH-bgd_pkg::THRESH_WIDTH){1'b0}},
                          timing_ff.tap_time};
         bgd_pkg::REG_HOLD_TIME:
            csr_prdata = {{(bgd_pkg::CSR_DATA_WIDTH-bgd_pkg::THRESH_WIDTH){1'b0}},
                          timing_ff.hold_time};
         bgd_pkg::REG_WAIT_TIME:
            csr_prdata = {{(bgd_pkg::CSR_DATA_WIDTH-bgd_pkg::THRESH_WIDTH){1'b0}},
                          timing_ff.wait_time};
         default:
            csr_prdata = '0;
      endcase
   end

   // one lane per button; lanes beyond the mask see a released button
   for (genvar i = 0; i < bgd_pkg::NUM_BUTTONS; i++) begin : g_lane
      bgd_pkg::lane_ctrl_type ctrl;
      if (i < bgd_pkg::MASK_WIDTH) begin : g_masked
         assign ctrl.pressed = req_data.pressed_mask[i];
      end else begin : g_unmasked
         assign ctrl.pressed = 1'b0;
      end
      assign ctrl.step   = accept;
      assign ctrl.now_ms = req_data.now_ms;

      bgd_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .timing (timing_ff),
         .state  (lane_state[i])
      );
   end

   // merge lane codes into the result and hold it for the consumer
   bgd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .lane_state (lane_state),
      .accept     (accept),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
